>>> hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FILL_W  = 4;

  typedef enum logic [1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic signed [DATA_W-1:0] data_t;

  // common shift and load controls for the cell row
  typedef struct packed {
    logic shift_rear;
    logic shift_front;
    logic load_tail;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/cdq_ifs.sv
`timescale 1ns / 1ps
interface cdq_in_if;
  import cdq_pkg::*;
  logic  valid;
  logic  ready;
  req_t  req_type;
  data_t push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;
  logic              valid;
  logic              ready;
  data_t             pop_value;
  status_t           status;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output pop_value, output status, output fill_count,
                  input ready);
  modport sink (input valid, input pop_value, input status, input fill_count,
                output ready);
endinterface

>>> hw/rtl/cdq_cell.sv
`timescale 1ns / 1ps
module cdq_cell (
  input  logic               clk,
  input  cdq_pkg::cell_ctrl_t ctrl,
  input  logic               tail_hit,
  input  cdq_pkg::data_t     prev_val,
  input  cdq_pkg::data_t     next_val,
  input  cdq_pkg::data_t     push_val,
  output cdq_pkg::data_t     val
);
  import cdq_pkg::*;

  data_t val_r;
  data_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift_rear) begin
      val_nxt = prev_val;
    end else if (ctrl.shift_front) begin
      val_nxt = next_val;
    end else if (ctrl.load_tail && tail_hit) begin
      val_nxt = push_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

>>> hw/rtl/circular_deque_core.sv
`timescale 1ns / 1ps
// a request's result is written into the output register when the request is accepted
// one request per cycle while results are taken; at most one step of the cell row each
// a result still waiting in the output register holds off the next request until taken
// reset clears count and output valid; cells and output data registers are not reset
module circular_deque_core (
  input  logic      clk,
  input  logic      rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);
  import cdq_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  data_t             pop_value_r;
  data_t             pop_value_nxt;
  status_t           status_r;
  status_t           status_nxt;
  logic [FILL_W-1:0] fill_r;

  logic       fire;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  data_t      cell_val [DEPTH];
  logic [DEPTH-1:0] tail_hit;
  logic [DEPTH-1:0] last_hit;
  data_t      rear_val;

  assign fire  = in_ch.valid & in_ch.ready;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign in_ch.ready = ~out_valid_r | out_ch.ready;

  // front of the deque is cell 0, rear is cell count-1
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      data_t prev_v;
      data_t next_v;
      if (i == 0) begin : g_first
        assign prev_v = in_ch.push_value;
      end else begin : g_mid
        assign prev_v = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_v = cell_val[i];
      end else begin : g_inner
        assign next_v = cell_val[i+1];
      end
      assign tail_hit[i] = (count_r == CNT_W'(i));
      assign last_hit[i] = (count_r == CNT_W'(i + 1));

      cdq_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .tail_hit (tail_hit[i]),
        .prev_val (prev_v),
        .next_val (next_v),
        .push_val (in_ch.push_value),
        .val      (cell_val[i])
      );
    end
  endgenerate

  always_comb begin
    rear_val = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rear_val = rear_val | (cell_val[k] & {DATA_W{last_hit[k]}});
    end
  end

  always_comb begin
    ctrl          = '0;
    count_nxt     = count_r;
    pop_value_nxt = '0;
    status_nxt    = ST_OK;
    case (in_ch.req_type)
      REQ_PUSH_REAR: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.load_tail = fire;
          count_nxt      = count_r + 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.shift_rear = fire;
          count_nxt       = count_r + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.shift_front = fire;
          pop_value_nxt    = cell_val[0];
          count_nxt        = count_r - 1'b1;
        end
      end
      REQ_POP_REAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop_value_nxt = rear_val;
          count_nxt     = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign out_valid_nxt = fire | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pop_value_r <= pop_value_nxt;
      status_r    <= status_nxt;
      fill_r      <= FILL_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pop_value  = pop_value_r;
  assign out_ch.status     = status_r;
  assign out_ch.fill_count = fill_r;

endmodule
